// ===== rtl/sorted_key_list_top_macros.svh =====
// ----------------------------------------------------------------------------
// sorted key list assertion macros
// shared concurrent assertion forms for the sorted key list rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_LIST_TOP_MACROS_SVH
`define SORTED_KEY_LIST_TOP_MACROS_SVH

// condition holds at every clock edge outside reset
`define SKL_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sorted key list invariant violated");

// cause in one cycle implies effect in the next
`define SKL_ASSERT_NEXT(label, clk, rst, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("sorted key list next-cycle check failed");

`endif

// ===== rtl/skl_pkg.sv =====
// ----------------------------------------------------------------------------
// skl_pkg
// types and constants shared by the sorted key list cells and top level
// ----------------------------------------------------------------------------
`default_nettype none

package skl_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 5;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } skl_status_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [KEY_W-1:0] key;
  } skl_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/skl_cell.sv =====
// ----------------------------------------------------------------------------
// skl_cell
// one slot of the sorted chain: holds a key, compares, shifts with neighbors
// ----------------------------------------------------------------------------
`default_nettype none

module skl_cell
  import skl_pkg::*;
(
  input  wire logic             clk,
  input  wire skl_ctrl_t        ctrl,
  input  wire logic             valid,
  input  wire logic             left_less,
  input  wire logic [KEY_W-1:0] left_key,
  input  wire logic [KEY_W-1:0] right_key,
  output logic      [KEY_W-1:0] key,
  output logic                  less,
  output logic                  eq
);

  logic [KEY_W-1:0] key_next;

  assign less = valid && ($signed(key) < $signed(ctrl.key));
  assign eq   = valid && (key == ctrl.key);

  always_comb begin
    key_next = key;
    if (ctrl.ins) begin
      if (!less) begin
        // first cell not below the new key takes it, the rest move right
        key_next = left_less ? ctrl.key : left_key;
      end
    end else if (ctrl.rem) begin
      if (!less) begin
        key_next = right_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_key_list_top.sv =====
// ----------------------------------------------------------------------------
// sorted_key_list_top
// sorted list of signed keys held in a row of compare-and-shift cells
// ----------------------------------------------------------------------------
// usage
//   slave channel carries one request: s_tuser is the action (insert or
//   remove), s_tdata the signed 32-bit key
//   master channel returns one result per request: m_tuser is the status
//   (done, list full, key not found), m_tdata the key count after the step
//   every cell compares its key against the request key in the same cycle;
//   the cells left of the slot keep their key, the rest shift one place,
//   so a request is done in the cycle it is accepted
//   the result is registered and valid in the cycle after the request is accepted
//   throughput: one request per cycle while results are taken, set by the
//   cell update and the output register; a new request is taken in the cycle the
//   previous result is taken
//   when m_tready is low and a result is held, s_tready drops until the
//   result is taken
//   reset clears the key count and the output valid; cell contents are
//   left as they are and only cells below the count are ever compared
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_key_list_top_macros.svh"

module sorted_key_list_top
  import skl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] key
  input  wire logic [0:0]  s_tuser,   // [0] action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata,   // [4:0] count, [7:5] zero
  output logic      [1:0]  m_tuser    // [1:0] status
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic               s_accept;
  logic               full;
  logic               found;
  skl_ctrl_t          ctrl;
  skl_status_t        status_next;
  logic [CAPACITY-1:0] valid;
  logic [CAPACITY-1:0] less;
  logic [CAPACITY-1:0] eq;
  logic [KEY_W-1:0]   keys [CAPACITY];
  logic [CW+COUNT_W-1:0] count_ext;

  // output register frees the input whenever it is empty or being drained
  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  assign full  = (count == CW'(CAPACITY));
  assign found = |eq;

  // only the request that really changes the list moves the cells
  always_comb begin
    ctrl.key = s_tdata;
    ctrl.ins = s_accept && (s_tuser[0] == ACT_INSERT) && !full;
    ctrl.rem = s_accept && (s_tuser[0] == ACT_REMOVE) && found;
  end

  always_comb begin
    count_next  = count;
    status_next = STATUS_DONE;
    if (s_tuser[0] == ACT_INSERT) begin
      if (full) begin
        status_next = STATUS_FULL;
      end else begin
        count_next = count + CW'(1);
      end
    end else begin
      if (!found) begin
        status_next = STATUS_NOT_FOUND;
      end else begin
        count_next = count - CW'(1);
      end
    end
  end

  // the chain of cells, index 0 holds the smallest key
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic             left_less;
    logic [KEY_W-1:0] left_key;
    logic [KEY_W-1:0] right_key;

    assign valid[g] = (CW'(g) < count);

    if (g == 0) begin : g_first
      assign left_less = 1'b1;
      assign left_key  = s_tdata;
    end else begin : g_mid
      assign left_less = less[g-1];
      assign left_key  = keys[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_key = keys[g];
    end else begin : g_inner
      assign right_key = keys[g+1];
    end

    skl_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .valid     (valid[g]),
      .left_less (left_less),
      .left_key  (left_key),
      .right_key (right_key),
      .key       (keys[g]),
      .less      (less[g]),
      .eq        (eq[g])
    );
  end

  // count field carries the low bits of the stored count
  assign count_ext = {{COUNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      m_tdata <= {3'b000, count_ext[COUNT_W-1:0]};
      m_tuser <= status_next;
    end
  end

  `SKL_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(CAPACITY))
  `SKL_ASSERT_NEXT(a_insert_grows, clk, rst, ctrl.ins, count == $past(count) + CW'(1))
  `SKL_ASSERT_NEXT(a_remove_shrinks, clk, rst, ctrl.rem, count == $past(count) - CW'(1))
  `SKL_ASSERT_NEXT(a_result_follows, clk, rst, s_accept, m_tvalid)
  `SKL_ASSERT_ALWAYS(a_full_refuses, clk, rst, !(ctrl.ins && full))

endmodule

`default_nettype wire

// ===== tb/sv/sorted_key_list_checker.sv =====
// ----------------------------------------------------------------------------
// sorted key list checker
// watches the request and result channels of the sorted key list, keeps its
// own ordered copy of the stored keys and compares every result with the
// status and count that copy predicts
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_key_list_checker
  import skl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] key
  input  wire logic [0:0]  s_tuser,   // [0] action
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [7:0]  m_tdata,   // [4:0] count, [7:5] zero
  input  wire logic [1:0]  m_tuser,   // [1:0] status
  output int unsigned      mismatches,
  output int unsigned      outstanding
);

  typedef struct packed {
    skl_status_t        status;
    logic [COUNT_W-1:0] count;
  } list_outcome_t;

  // ascending copy of the keys held by the block
  logic signed [KEY_W-1:0] ordered_keys[$];
  // predicted outcomes still waiting for their result
  list_outcome_t           pending_outcomes[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  function automatic list_outcome_t apply_list_request(input logic action,
                                                       input logic signed [KEY_W-1:0] key);
    list_outcome_t outcome;
    int            slot;
    outcome.status = STATUS_DONE;
    slot = 0;
    if (action == ACT_INSERT) begin
      if (ordered_keys.size() >= CAPACITY) begin
        outcome.status = STATUS_FULL;
      end else begin
        // among equal keys the slot is invisible, so go before the first not-smaller one
        while (slot < ordered_keys.size() && ordered_keys[slot] < key) slot++;
        ordered_keys.insert(slot, key);
      end
    end else begin
      while (slot < ordered_keys.size() && ordered_keys[slot] != key) slot++;
      if (slot >= ordered_keys.size()) begin
        outcome.status = STATUS_NOT_FOUND;
      end else begin
        ordered_keys.delete(slot);
      end
    end
    outcome.count = COUNT_W'(ordered_keys.size());
    return outcome;
  endfunction

  always @(posedge clk) begin
    list_outcome_t want;
    if (rst) begin
      ordered_keys.delete();
      pending_outcomes.delete();
    end else begin
      // a result is registered and never returns in the cycle its request is accepted, so check first
      if (m_tvalid && m_tready) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch($sformatf("unexpected result: status %0d count %0d",
                                    m_tuser, m_tdata[COUNT_W-1:0]));
        end else begin
          want = pending_outcomes.pop_front();
          if (m_tuser !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d", m_tuser, want.status));
          if (m_tdata[COUNT_W-1:0] !== want.count)
            report_mismatch($sformatf("count %0d, predicted %0d",
                                      m_tdata[COUNT_W-1:0], want.count));
        end
      end
      if (s_tvalid && s_tready)
        pending_outcomes.push_back(apply_list_request(s_tuser[0], $signed(s_tdata)));
    end
    outstanding <= pending_outcomes.size();
  end

endmodule

// ===== tb/sv/sorted_key_list_top_tb.sv =====
// ----------------------------------------------------------------------------
// sorted key list testbench
// drives insert and remove requests into the sorted key list under random
// bursts, gaps and output stalls; a separate checker predicts each status
// and count and this top gives the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_key_list_top_tb;
  import skl_pkg::*;

  localparam int          CAPACITY     = 16;
  localparam int          CLK_PERIOD   = 8;
  localparam int          RANDOM_COUNT = 550;
  localparam int          HOLD_CYCLES  = 150;   // long receiver hold-off
  localparam int          SETTLE       = 20;    // quiet cycles before the verdict
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          POOL_SIZE    = 8;
  localparam logic [31:0] KEY_MIN      = 32'h8000_0000;
  localparam logic [31:0] KEY_MAX      = 32'h7FFF_FFFF;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // [31:0] key
  logic [0:0]  s_tuser  = '0;   // [0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [4:0] count, [7:5] zero
  logic [1:0]  m_tuser;         // [1:0] status

  int unsigned mismatches;
  int unsigned outstanding;

  // sender burst state
  int unsigned burst_left = 1;
  bit          gapless    = 1'b0;

  // receiver state; hold_requests is bumped by the stimulus, served by the receiver
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  int unsigned mode_left     = 0;
  int unsigned stall_mode    = 0;
  int unsigned pattern_tick  = 0;

  int unsigned cycle_count = 0;

  // random phase state
  logic [31:0] key_pool[POOL_SIZE];
  int unsigned random_sent;
  int unsigned phase;
  int unsigned phase_len;
  int unsigned insert_pct;
  logic        action;
  logic [31:0] key;

  always #(CLK_PERIOD / 2.0) clk = ~clk;

  sorted_key_list_top #(
    .CAPACITY (CAPACITY)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  sorted_key_list_checker #(
    .CAPACITY (CAPACITY)
  ) list_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // watchdog: a hang or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("sorted_key_list_top_tb NOT OK");
      $finish;
    end
  end

  // receiver: long hold-offs on request, otherwise stall modes of random length
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES - 1;
      m_tready     <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(8, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
      pattern_tick <= pattern_tick + 1;
      case (stall_mode)
        0: begin
          m_tready <= 1'b1;                        // no stalls at all
        end
        1: begin
          m_tready <= 1'($urandom_range(0, 1));    // coin toss
        end
        2: begin
          m_tready <= (pattern_tick % 3) != 0;     // two on, one off
        end
        default: begin
          m_tready <= $urandom_range(0, 4) == 0;   // mostly stalled
        end
      endcase
    end
  end

  // offer one request and wait for its handshake; gaps fall between bursts
  task automatic send_request(input logic act, input logic [31:0] k);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= k;
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !gapless) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;          // idle bus carries junk
      s_tuser  <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                               : $urandom_range(1, 8);
    end
    if (burst_left == 0) burst_left = $urandom_range(1, 8);
  endtask

  // stop offering until every predicted result has come back
  task automatic wait_drained;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // keys for one phase: a small pool so removes hit and duplicates occur
  task automatic refresh_key_pool;
    for (int i = 0; i < POOL_SIZE; i++) begin
      case ($urandom_range(0, 5))
        0: key_pool[i] = KEY_MIN;
        1: key_pool[i] = KEY_MAX;
        2: key_pool[i] = (i > 0) ? key_pool[i-1] + 32'd1 : 32'd0;
        default: key_pool[i] = $urandom;
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, extremes, duplicates, absent key, full list
    send_request(ACT_REMOVE, 32'd7);              // remove from an empty list
    send_request(ACT_INSERT, KEY_MAX);
    send_request(ACT_INSERT, KEY_MIN);
    send_request(ACT_INSERT, 32'd0);
    send_request(ACT_INSERT, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 32'd1);
    send_request(ACT_INSERT, 32'hFFFF_FFFF);      // equal key already stored
    send_request(ACT_REMOVE, 32'd2);              // absent key
    send_request(ACT_REMOVE, 32'hFFFF_FFFF);      // one of the two equal keys
    for (int i = 0; i < 11; i++)
      send_request(ACT_INSERT, $urandom);          // fill to capacity
    send_request(ACT_INSERT, 32'd5);              // refused, list full
    send_request(ACT_REMOVE, KEY_MIN);            // remove from a full list
    wait_drained();

    // random phases: fill-heavy, drain-heavy and mixed, with pool keys
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_COUNT) begin
      refresh_key_pool();
      case ($urandom_range(0, 2))
        0: insert_pct = 80;
        1: insert_pct = 25;
        default: insert_pct = 50;
      endcase

      // long output hold while requests keep coming, so the input stalls
      if (phase == 1 || phase % 6 == 4) begin
        hold_requests++;
        gapless = 1'b1;
        for (int i = 0; i < 12; i++)
          send_request(1'($urandom_range(0, 1)), key_pool[$urandom_range(0, POOL_SIZE-1)]);
        gapless = 1'b0;
        random_sent += 12;
      end

      phase_len = $urandom_range(20, 50);
      for (int i = 0; i < phase_len; i++) begin
        action = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
        // a few keys from the whole range keep every bit moving
        key = ($urandom_range(0, 19) == 0) ? $urandom
                                           : key_pool[$urandom_range(0, POOL_SIZE-1)];
        send_request(action, key);
      end
      random_sent += phase_len;

      if (phase % 4 == 3) wait_drained();
      phase++;
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("sorted_key_list_top_tb OK");
    end else begin
      $display("sorted_key_list_top_tb NOT OK");
    end
    $finish;
  end

endmodule
